>>> src/pce_pkg.sv
// Package: shared types, codes and helper functions for the calculator engine
`timescale 1ns / 1ps
package pce_pkg;

    localparam int DATA_W  = 64;
    localparam int BASE_W  = 5;
    localparam int WBITS_W = 7;
    localparam int CNT_W   = 7;

    localparam logic [2:0] F_DIGIT = 3'd0;
    localparam logic [2:0] F_OPER  = 3'd1;
    localparam logic [2:0] F_NEG   = 3'd2;
    localparam logic [2:0] F_INV   = 3'd3;
    localparam logic [2:0] F_EQ    = 3'd4;
    localparam logic [2:0] F_CLR   = 3'd5;
    localparam logic [2:0] F_BS    = 3'd6;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MOD  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_XOR  = 4'd7;
    localparam logic [3:0] OP_SHL  = 4'd8;
    localparam logic [3:0] OP_SAR  = 4'd9;
    localparam logic [3:0] OP_NONE = 4'd15;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIVZ   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic       CFG_BASE  = 1'b0;
    localparam logic       CFG_WBITS = 1'b1;

    localparam logic [BASE_W-1:0]  BASE_RESET  = 5'd10;
    localparam logic [WBITS_W-1:0] WBITS_RESET = 7'd32;

    typedef enum logic [0:0] {
        ITER_MUL = 1'b0,
        ITER_DIV = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic load;
        logic start;
        logic commit;
    } pce_cmd_t;

    typedef struct packed {
        logic needs_iter;
        logic iter_done;
        logic out_free;
    } pce_sts_t;

    function automatic logic [DATA_W-1:0] width_mask(input logic [WBITS_W-1:0] wb);
        logic [DATA_W-1:0] m;
        m = '0;
        if (wb == '0) begin
            m = '0;
        end else if (wb >= WBITS_W'(DATA_W)) begin
            m = '1;
        end else begin
            m = ~({DATA_W{1'b1}} << wb[5:0]);
        end
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] wrap_width(input logic [DATA_W-1:0] v,
                                                     input logic [WBITS_W-1:0] wb);
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] r;
        logic [5:0]        top;
        m   = width_mask(wb);
        top = wb[5:0] - 6'd1;
        r   = v;
        if (wb == '0) begin
            r = '0;
        end else if (wb < WBITS_W'(DATA_W)) begin
            r = v & m;
            if (v[top]) begin
                r = r | ~m;
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] abs64(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

endpackage

>>> src/pce_iter.sv
// Iterative unit: 64-step shift-add multiplier and restoring divider
`timescale 1ns / 1ps
module pce_iter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  pce_pkg::iter_mode_t        mode,
    input  logic [pce_pkg::DATA_W-1:0] op_a,
    input  logic [pce_pkg::DATA_W-1:0] op_b,
    output logic                       done,
    output logic [pce_pkg::DATA_W-1:0] product,
    output logic [pce_pkg::DATA_W-1:0] quotient,
    output logic [pce_pkg::DATA_W-1:0] remainder
);
    import pce_pkg::*;

    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    iter_mode_t        mode_reg, mode_next;
    logic [DATA_W:0]   rr;
    logic [DATA_W:0]   diff;

    always_comb begin
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        mode_next = mode_reg;
        rr        = {r_reg, q_reg[DATA_W-1]};
        diff      = rr - {1'b0, d_reg};
        if (start) begin
            mode_next = mode;
            r_next    = '0;
            q_next    = op_a;
            d_next    = op_b;
            if (mode == ITER_MUL) begin
                q_next = op_b;
                d_next = op_a;
            end
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (mode_reg == ITER_MUL) begin
                if (q_reg[0]) begin
                    r_next = r_reg + d_reg;
                end
                d_next = {d_reg[DATA_W-2:0], 1'b0};
                q_next = {1'b0, q_reg[DATA_W-1:1]};
            end else begin
                if (!diff[DATA_W]) begin
                    r_next = diff[DATA_W-1:0];
                end else begin
                    r_next = rr[DATA_W-1:0];
                end
                q_next = {q_reg[DATA_W-2:0], ~diff[DATA_W]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= ITER_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign product   = r_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> src/pce_ctrl.sv
// Controller: sequences accept, execute, iterate and commit of one key transaction
`timescale 1ns / 1ps
module pce_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pce_pkg::pce_sts_t sts,
    output pce_pkg::pce_cmd_t cmd
);
    import pce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_ITER   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.needs_iter) begin
                    cmd.start  = 1'b1;
                    state_next = S_ITER;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_ITER: begin
                if (sts.iter_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/pce_datapath.sv
// Datapath: calculator state, key decode, result commit and output register
`timescale 1ns / 1ps
module pce_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [2:0]                  s_tuser,
    input  logic [7:0]                  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [pce_pkg::WBITS_W-1:0] cfg_wdata,
    input  pce_pkg::pce_cmd_t           cmd,
    output pce_pkg::pce_sts_t           sts
);
    import pce_pkg::*;

    logic [BASE_W-1:0]  base_reg;
    logic [WBITS_W-1:0] wb_reg;
    logic [DATA_W-1:0]  cur_reg, cur_next;
    logic [DATA_W-1:0]  sto_reg, sto_next;
    logic [3:0]         pend_reg, pend_next;
    logic [DATA_W-1:0]  mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               pres_reg, pres_next;
    logic               shown_reg, shown_next;
    logic [2:0]         func_reg;
    logic [3:0]         digit_reg;
    logic [3:0]         op_reg;
    logic               outv_reg;
    logic [DATA_W-1:0]  outd_reg;
    logic [1:0]         outs_reg;
    logic [1:0]         status;

    logic               pend_div, pend_long, calc_ok, chain, eq, bs_div;
    iter_mode_t         it_mode;
    logic [DATA_W-1:0]  it_a, it_b, it_prod, it_quot, it_rem;
    logic               it_done;
    logic [DATA_W-1:0]  calc_r, quot_abs;
    logic [5:0]         sh;
    logic [DATA_W-1:0]  eff_mag, newcur;
    logic               eff_neg;
    logic [DATA_W+BASE_W:0] dig_sum, dig_lim;
    logic [DATA_W-1:0]  bs_val;

    assign pend_div  = (pend_reg == OP_DIV) || (pend_reg == OP_MOD);
    assign pend_long = pend_div || (pend_reg == OP_MUL);
    assign calc_ok   = !(pend_div && (cur_reg == '0));
    assign chain     = (func_reg == F_OPER) && (op_reg <= OP_SAR) && (pend_reg != OP_NONE);
    assign eq        = (func_reg == F_EQ) && (pend_reg != OP_NONE);
    assign bs_div    = (func_reg == F_BS) && pres_reg && (base_reg >= BASE_W'(2))
                       && (mag_reg >= DATA_W'(base_reg));

    always_comb begin
        if (bs_div) begin
            it_mode = ITER_DIV;
            it_a    = mag_reg;
            it_b    = DATA_W'(base_reg);
        end else if (pend_reg == OP_MUL) begin
            it_mode = ITER_MUL;
            it_a    = sto_reg;
            it_b    = cur_reg;
        end else begin
            it_mode = ITER_DIV;
            it_a    = abs64(sto_reg);
            it_b    = abs64(cur_reg);
        end
    end

    pce_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start),
        .mode      (it_mode),
        .op_a      (it_a),
        .op_b      (it_b),
        .done      (it_done),
        .product   (it_prod),
        .quotient  (it_quot),
        .remainder (it_rem)
    );

    assign sts.needs_iter = ((chain || eq) && pend_long && calc_ok) || bs_div;
    assign sts.iter_done  = it_done;
    assign sts.out_free   = !outv_reg || m_tready;

    // pending operation result
    always_comb begin
        sh       = cur_reg[5:0];
        quot_abs = it_quot;
        unique case (pend_reg)
            OP_ADD:  calc_r = sto_reg + cur_reg;
            OP_SUB:  calc_r = sto_reg - cur_reg;
            OP_MUL:  calc_r = it_prod;
            OP_DIV:  calc_r = (sto_reg[DATA_W-1] != cur_reg[DATA_W-1]) ?
                              (DATA_W'(0) - quot_abs) : quot_abs;
            OP_MOD:  calc_r = sto_reg[DATA_W-1] ? (DATA_W'(0) - it_rem) : it_rem;
            OP_AND:  calc_r = sto_reg & cur_reg;
            OP_OR:   calc_r = sto_reg | cur_reg;
            OP_XOR:  calc_r = sto_reg ^ cur_reg;
            OP_SHL:  calc_r = sto_reg << sh;
            OP_SAR:  calc_r = DATA_W'($signed(sto_reg) >>> sh);
            default: calc_r = cur_reg;
        endcase
    end

    assign eff_mag = shown_reg ? '0 : mag_reg;
    assign eff_neg = shown_reg ? 1'b0 : neg_reg;
    assign dig_sum = ({(BASE_W+1)'(0), eff_mag} * {{(DATA_W+1){1'b0}}, base_reg})
                     + (DATA_W+BASE_W+1)'(digit_reg);
    assign dig_lim = eff_neg ? (DATA_W+BASE_W+1)'({1'b1, {(DATA_W-1){1'b0}}})
                             : (DATA_W+BASE_W+1)'({1'b0, {(DATA_W-1){1'b1}}});
    assign bs_val  = neg_reg ? (DATA_W'(0) - it_quot) : it_quot;

    always_comb begin
        cur_next   = cur_reg;
        sto_next   = sto_reg;
        pend_next  = pend_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        pres_next  = pres_reg;
        shown_next = shown_reg;
        status     = ST_OK;
        newcur     = cur_reg;
        unique case (func_reg)
            F_DIGIT: begin
                if (shown_reg) begin
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    pres_next  = 1'b0;
                    shown_next = 1'b0;
                end
                if ((BASE_W'(digit_reg) >= base_reg) || (dig_sum > dig_lim)) begin
                    status = ST_REJECT;
                end else begin
                    mag_next  = dig_sum[DATA_W-1:0];
                    pres_next = 1'b1;
                    cur_next  = wrap_width(eff_neg ? (DATA_W'(0) - dig_sum[DATA_W-1:0])
                                                   : dig_sum[DATA_W-1:0], wb_reg);
                end
            end
            F_OPER: begin
                if (op_reg <= OP_SAR) begin
                    newcur = cur_reg;
                    if (chain && calc_ok) begin
                        newcur = wrap_width(calc_r, wb_reg);
                    end
                    cur_next   = newcur;
                    sto_next   = newcur;
                    pend_next  = op_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    pres_next  = 1'b0;
                    shown_next = 1'b0;
                end
            end
            F_NEG, F_INV, F_EQ: begin
                if (func_reg == F_NEG) begin
                    newcur = wrap_width(DATA_W'(0) - cur_reg, wb_reg);
                end else if (func_reg == F_INV) begin
                    newcur = wrap_width(~cur_reg, wb_reg);
                end else begin
                    newcur = wrap_width(calc_r, wb_reg);
                end
                if ((func_reg == F_EQ) && !eq) begin
                    newcur = cur_reg;
                end else if ((func_reg == F_EQ) && !calc_ok) begin
                    status = ST_DIVZ;
                end else begin
                    cur_next  = newcur;
                    pres_next = 1'b1;
                    if (base_reg == BASE_W'(10)) begin
                        neg_next = newcur[DATA_W-1];
                        mag_next = abs64(newcur);
                    end else begin
                        neg_next = 1'b0;
                        mag_next = newcur & width_mask(wb_reg);
                    end
                    if (func_reg == F_EQ) begin
                        pend_next  = OP_NONE;
                        shown_next = 1'b1;
                    end
                end
            end
            F_CLR: begin
                cur_next   = '0;
                sto_next   = '0;
                pend_next  = OP_NONE;
                mag_next   = '0;
                neg_next   = 1'b0;
                pres_next  = 1'b0;
                shown_next = 1'b0;
            end
            F_BS: begin
                if (pres_reg) begin
                    if (bs_div) begin
                        mag_next = it_quot;
                        cur_next = wrap_width(bs_val, wb_reg);
                    end else begin
                        mag_next  = '0;
                        neg_next  = 1'b0;
                        pres_next = 1'b0;
                        cur_next  = '0;
                    end
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RESET;
            wb_reg    <= WBITS_RESET;
            cur_reg   <= '0;
            sto_reg   <= '0;
            pend_reg  <= OP_NONE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            pres_reg  <= 1'b0;
            shown_reg <= 1'b0;
            outv_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_BASE) begin
                    base_reg <= cfg_wdata[BASE_W-1:0];
                end else begin
                    wb_reg <= cfg_wdata;
                end
            end
            if (cmd.commit) begin
                cur_reg   <= cur_next;
                sto_reg   <= sto_next;
                pend_reg  <= pend_next;
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                pres_reg  <= pres_next;
                shown_reg <= shown_next;
                outv_reg  <= 1'b1;
            end else if (m_tready) begin
                outv_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            func_reg  <= s_tuser;
            digit_reg <= s_tdata[3:0];
            op_reg    <= s_tdata[7:4];
        end
        if (cmd.commit) begin
            outd_reg <= cur_next;
            outs_reg <= status;
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = {6'b0, outs_reg, outd_reg};

endmodule

>>> src/programmer_calculator_engine.sv
// Top level: programmer calculator engine, one key transaction at a time
//
// Usage:
//   Keys enter on the s_ stream: s_tuser carries the key kind, s_tdata the
//   digit and operator code. Every key transaction produces exactly one
//   m_ transaction carrying the current value and a status code.
//   Radix and word width are set through cfg_we/cfg_addr/cfg_wdata; the user
//   writes them only while no key is in flight (the block does not enforce it).
// Sequencing:
//   Simple keys go from accept through execute to commit. Multiply, divide and
//   modulo (on equals or chained operators) and backspace on a multi-digit
//   entry also run the shared 64-step iterative unit before commit. One key is in
//   flight at a time; s_tready rises again after the result is registered.
// Reset:
//   aresetn (synchronous, active low) clears the value, operand, entry and
//   pending operator, sets radix 10 and width 32, and drops m_tvalid.
// Stall:
//   The result waits in the output register while m_tready is low; the next
//   key is accepted and computed meanwhile but holds before commit.
`timescale 1ns / 1ps
module programmer_calculator_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // digit_value[3:0], operator_code[7:4]
    input  logic [2:0]                  s_tuser,   // func[2:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,   // current_out[63:0], status[65:64], zero
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [pce_pkg::WBITS_W-1:0] cfg_wdata
);
    import pce_pkg::*;

    pce_cmd_t cmd;
    pce_sts_t sts;

    pce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pce_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> src/pce_checker.sv
// Checker: port-level properties of the calculator engine, bound to the top level
`timescale 1ns / 1ps
module pce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second key accepted while one in flight");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:64] != 2'b11) && (m_tdata[71:66] == 6'b0))
        else $error("illegal status or padding");

endmodule

bind programmer_calculator_engine pce_checker u_pce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
